// File: hdl/fvp_pkg.sv
// ----------------------------------------------------------------------------
// fvp_pkg
// Shared types and codes for the flash vector patcher: action and result
// kinds, configuration register indexes, datapath commands and status.
// ----------------------------------------------------------------------------
package fvp_pkg;

  // input action codes
  localparam logic [1:0] ACT_SET_ADDR = 2'd0;
  localparam logic [1:0] ACT_DATA     = 2'd1;
  localparam logic [1:0] ACT_FINISH   = 2'd2;
  localparam logic [1:0] ACT_ERASE    = 2'd3;

  // result kind codes
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_ERASE  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_BASE      = 3'd0;
  localparam logic [2:0] CFG_USB_INDEX = 3'd1;
  localparam logic [2:0] CFG_VUSB_ADJ  = 3'd2;
  localparam logic [2:0] CFG_OSC_CAL   = 3'd3;
  localparam logic [2:0] CFG_STORE_CAL = 3'd4;

  // instruction word constants
  localparam logic [15:0] RJMP_OP = 16'hC000;
  localparam logic [15:0] BLANK   = 16'hFFFF;

  // configuration register file
  typedef struct packed {
    logic [12:0] base;
    logic [4:0]  usb_index;
    logic [2:0]  vusb_adjust;
    logic [7:0]  osc_cal;
    logic        store_cal;
  } cfg_t;

  // controller to datapath command
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SET_ADDR,
    CMD_DATA,
    CMD_FINISH,
    CMD_ERASE,
    CMD_FILL
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic aligned;
    logic fill_done;
  } dp_status_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

endpackage

// File: hdl/flash_vector_patcher.sv
// ----------------------------------------------------------------------------
// flash_vector_patcher
// Patches a stream of flash image words for a two-byte vector bootloader:
// redirects the reset and USB vectors and writes the jump table back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, start_address and word.
//   Output channel (out_valid/out_ready) carries kind, fill_address,
//   fill_word, commit and last; last marks the final result of an item.
//   Set address and data words complete with their transfer, and a data
//   word result appears in the output register in the cycle after its
//   transfer, so data words stream at one per cycle while the receiver
//   keeps up. Finish on an unaligned page emits padding words up to the
//   page end; erase emits one erase result then PAGE_BYTES/2 words. The
//   fill sequencer produces these words one per cycle while the receiver
//   keeps up, and the input is held off until it has produced the last.
//   When the receiver stalls, the result waits in the output register and
//   no new item or fill word is taken until it leaves.
//   Reset clears the write address and saved targets and loads the register
//   defaults; the block is ready as soon as reset is released.
//   Configuration writes (cfg_we) are registered and must be made only
//   while the block is idle, which the block does not enforce.
//   FLASH_BYTES and PAGE_BYTES must be powers of two; this is not checked.
// ----------------------------------------------------------------------------
module flash_vector_patcher
  import fvp_pkg::*;
#(
  parameter int FLASH_BYTES = 8192,
  parameter int PAGE_BYTES  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [12:0] start_address,
  input  logic [15:0] word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [12:0] fill_address,
  output logic [15:0] fill_word,
  output logic        commit,
  output logic        last
);

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base        <= 13'd6074;
      cfg.usb_index   <= 5'd1;
      cfg.vusb_adjust <= 3'd0;
      cfg.osc_cal     <= 8'd0;
      cfg.store_cal   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:      cfg.base        <= cfg_wdata;
        CFG_USB_INDEX: cfg.usb_index   <= cfg_wdata[4:0];
        CFG_VUSB_ADJ:  cfg.vusb_adjust <= cfg_wdata[2:0];
        CFG_OSC_CAL:   cfg.osc_cal     <= cfg_wdata[7:0];
        CFG_STORE_CAL: cfg.store_cal   <= cfg_wdata[0];
        default:       cfg.store_cal   <= cfg.store_cal;
      endcase
    end
  end

  // controller
  fvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  fvp_datapath #(
    .FLASH_BYTES (FLASH_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .start_address (start_address),
    .word          (word),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .fill_address  (fill_address),
    .fill_word     (fill_word),
    .commit        (commit),
    .last          (last)
  );

endmodule

// File: hdl/fvp_ctrl.sv
// ----------------------------------------------------------------------------
// fvp_ctrl
// Controller: takes input transfers while idle and sequences page fill runs
// one word per free output slot.
// ----------------------------------------------------------------------------
module fvp_ctrl
  import fvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  dp_status_t status,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_ERASE) begin
            state_next = ST_FILL;
          end else if (action == ACT_FINISH && !status.aligned) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (status.out_free && status.fill_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          unique case (action)
            ACT_SET_ADDR: cmd = CMD_SET_ADDR;
            ACT_DATA:     cmd = CMD_DATA;
            ACT_FINISH:   cmd = CMD_FINISH;
            ACT_ERASE:    cmd = CMD_ERASE;
            default:      cmd = CMD_NONE;
          endcase
        end
      end
      ST_FILL: begin
        if (status.out_free) begin
          cmd = CMD_FILL;
        end
      end
      default: cmd = CMD_NONE;
    endcase
  end

endmodule

// File: hdl/fvp_datapath.sv
// ----------------------------------------------------------------------------
// fvp_datapath
// Datapath: write address, saved vector targets, word patching, fill
// counter and the output register.
// ----------------------------------------------------------------------------
module fvp_datapath
  import fvp_pkg::*;
#(
  parameter int FLASH_BYTES = 8192,
  parameter int PAGE_BYTES  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  cfg_t        cfg,
  input  logic [12:0] start_address,
  input  logic [15:0] word,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [12:0] fill_address,
  output logic [15:0] fill_word,
  output logic        commit,
  output logic        last
);

  localparam int AW = $clog2(FLASH_BYTES);
  localparam int PW = $clog2(PAGE_BYTES);
  localparam logic [PW-1:0] FILL_LAST = PW'(PAGE_BYTES / 2 - 1);

  logic [AW-1:0] write_address;
  logic [15:0]   saved_reset_target;
  logic [15:0]   saved_usb_target;
  logic [PW-1:0] fill_count;

  logic [14:0]   addr_ext;
  logic [14:0]   base_ext;
  logic [14:0]   start_ext;
  logic [14:0]   prev_ext;
  logic [AW-1:0] addr_adv;
  logic [AW-1:0] addr_prev;
  logic          is_zero;
  logic          is_usb;
  logic          is_tab0;
  logic          is_tab1;
  logic          is_cal;
  logic          above_base;
  logic          drop;
  logic          adv_aligned;
  logic          fill_done;
  logic [15:0]   rj_reset;
  logic [15:0]   rj_usb;
  logic [15:0]   rj_tab0;
  logic [15:0]   rj_tab1;
  logic [15:0]   raw_word;
  logic [15:0]   patched;
  logic          load;
  logic [1:0]    load_kind;
  logic [12:0]   load_addr;
  logic [15:0]   load_word;
  logic          load_commit;
  logic          load_last;

  // address arithmetic
  assign addr_ext    = 15'(write_address);
  assign base_ext    = {2'b00, cfg.base};
  assign start_ext   = {2'b00, start_address[12:1], 1'b0};
  assign addr_adv    = write_address + AW'(2);
  assign addr_prev   = write_address - AW'(2);
  assign prev_ext    = 15'(addr_prev);
  assign adv_aligned = (addr_adv[PW-1:0] == '0);
  assign fill_done   = adv_aligned || (fill_count == FILL_LAST);

  // special address matches
  assign is_zero    = (write_address == '0);
  assign is_usb     = (addr_ext == {9'd0, cfg.usb_index, 1'b0});
  assign is_tab0    = (addr_ext == base_ext);
  assign is_tab1    = (addr_ext == base_ext + 15'd2);
  assign is_cal     = cfg.store_cal && (addr_ext == base_ext + 15'd4);
  assign above_base = (addr_ext >= base_ext + 15'd6);
  assign drop       = !is_zero && !is_usb && above_base;

  // relative jump encodings
  assign rj_reset = RJMP_OP | {4'd0, 12'(16'((base_ext + 15'd6) >> 1) - 16'd1)};
  assign rj_usb   = RJMP_OP | {4'd0, 12'(16'((base_ext + 15'd8) >> 1)
                                        - 16'(cfg.usb_index) - 16'd1)};
  assign rj_tab0  = RJMP_OP | {4'd0, 12'(saved_reset_target
                                        - 16'(base_ext >> 1) - 16'd1)};
  assign rj_tab1  = RJMP_OP | {4'd0, 12'(saved_usb_target
                                        - 16'((base_ext + 15'd2) >> 1) - 16'd1)};

  // word patching, reset vector first
  assign raw_word = (cmd == CMD_DATA) ? word : BLANK;
  always_comb begin
    priority if (is_zero) begin
      patched = rj_reset;
    end else if (is_usb) begin
      patched = rj_usb;
    end else if (is_tab0) begin
      patched = rj_tab0;
    end else if (is_tab1) begin
      patched = rj_tab1;
    end else if (is_cal) begin
      patched = {8'd0, cfg.osc_cal};
    end else begin
      patched = raw_word;
    end
  end

  // result selection
  always_comb begin
    load        = 1'b0;
    load_kind   = KIND_WORD;
    load_addr   = addr_ext[12:0];
    load_word   = patched;
    load_commit = 1'b0;
    load_last   = 1'b0;
    unique case (cmd)
      CMD_DATA: begin
        load        = !drop;
        load_commit = adv_aligned;
        load_last   = 1'b1;
      end
      CMD_FINISH: begin
        load        = status.aligned;
        load_kind   = KIND_COMMIT;
        load_addr   = prev_ext[12:0];
        load_word   = 16'd0;
        load_commit = 1'b1;
        load_last   = 1'b1;
      end
      CMD_ERASE: begin
        load      = 1'b1;
        load_kind = KIND_ERASE;
        load_addr = 13'd0;
        load_word = BLANK;
      end
      CMD_FILL: begin
        load        = 1'b1;
        load_commit = fill_done;
        load_last   = fill_done;
      end
      default: load = 1'b0;
    endcase
  end

  // address, targets and fill counter
  always_ff @(posedge clk) begin
    if (rst) begin
      write_address      <= '0;
      saved_reset_target <= '0;
      saved_usb_target   <= '0;
      fill_count         <= '0;
    end else begin
      unique case (cmd)
        CMD_SET_ADDR: write_address <= start_ext[AW-1:0];
        CMD_DATA: begin
          if (is_zero) begin
            saved_reset_target <= word + 16'd1;
          end else if (is_usb) begin
            saved_usb_target <= word + 16'(cfg.vusb_adjust)
                                + 16'(cfg.usb_index) + 16'd1;
          end
          if (!drop) begin
            write_address <= addr_adv;
          end
        end
        CMD_FINISH: fill_count <= '0;
        CMD_ERASE: begin
          write_address <= '0;
          fill_count    <= '0;
        end
        CMD_FILL: begin
          write_address <= addr_adv;
          fill_count    <= fill_count + PW'(1);
        end
        default: fill_count <= fill_count;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= load_kind;
      fill_address <= load_addr;
      fill_word    <= load_word;
      commit       <= load_commit;
      last         <= load_last;
    end
  end

  // status to controller
  assign status.out_free  = !out_valid || out_ready;
  assign status.aligned   = (write_address[PW-1:0] == '0);
  assign status.fill_done = fill_done;

endmodule
